/* rtl/core/adcseq_pkg.sv */
`timescale 1ns / 1ps

package adcseq_pkg;

    // Default sizing of the sequencer.
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 12;

    // Field widths that are fixed by the register map.
    localparam int SETTLE_W  = 8;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // Register reset values.
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd5;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LEN     = 1'd1;

    // Strobes produced by one sequencer step.
    typedef struct packed {
        logic mux_load;
        logic conv_start;
        logic sample_valid;
    } adcseq_strobe_t;

endpackage

/* rtl/core/adcseq_store.sv */
`timescale 1ns / 1ps

module adcseq_store #(
    parameter int DEPTH  = adcseq_pkg::MAX_CHANNELS_DEF,
    parameter int DATA_W = adcseq_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W  = $clog2(adcseq_pkg::MAX_CHANNELS_DEF)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic              rd_in_range;

    // The store starts out cleared and takes one sample per write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                mem_reg[i] <= '0;
            end
        end else if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read shows the contents after this step's write; indexes past the store read zero.
    assign rd_in_range = ({1'b0, rd_addr} < (IDX_W + 1)'(DEPTH));

    always_comb begin
        if (!rd_in_range) begin
            rd_data = '0;
        end else if (wr_en && (wr_addr == rd_addr)) begin
            rd_data = wr_data;
        end else begin
            rd_data = mem_reg[rd_addr];
        end
    end

endmodule

/* rtl/core/adcseq_ctrl.sv */
`timescale 1ns / 1ps

module adcseq_ctrl #(
    parameter int MAX_CHANNELS = adcseq_pkg::MAX_CHANNELS_DEF,
    parameter int CH_W         = $clog2(adcseq_pkg::MAX_CHANNELS_DEF)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             advance,
    input  logic                             conv_done,
    input  logic [adcseq_pkg::SETTLE_W-1:0]  settle_ticks,
    input  logic [adcseq_pkg::COUNT_W-1:0]   scan_len,
    output adcseq_pkg::adcseq_strobe_t       strobe,
    output logic [CH_W-1:0]                  channel,
    output logic                             scan_done
);

    import adcseq_pkg::*;

    localparam int LIM_W = (CH_W + 1 > COUNT_W) ? CH_W + 1 : COUNT_W;

    typedef enum logic [2:0] {
        PH_SET_MUX  = 3'd0,
        PH_SETTLE   = 3'd1,
        PH_START    = 3'd2,
        PH_WAIT_EOC = 3'd3,
        PH_READ     = 3'd4,
        PH_NEXT     = 3'd5
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [SETTLE_W-1:0] settle_cnt_reg, settle_cnt_next;
    logic [CH_W-1:0]     channel_reg, channel_next;
    logic                pass_done_reg, pass_done_next;
    logic [LIM_W-1:0]    count_ext;
    logic [LIM_W-1:0]    limit;
    logic [LIM_W-1:0]    channel_inc;

    // Channels per pass: zero acts as one, and the count saturates at the store depth.
    always_comb begin
        count_ext = LIM_W'(scan_len);
        if (count_ext == '0) begin
            limit = LIM_W'(1);
        end else if (count_ext > LIM_W'(MAX_CHANNELS)) begin
            limit = LIM_W'(MAX_CHANNELS);
        end else begin
            limit = count_ext;
        end
        channel_inc = LIM_W'(channel_reg) + LIM_W'(1);
    end

    // One phase step per accepted word.
    always_comb begin
        phase_next      = phase_reg;
        settle_cnt_next = settle_cnt_reg;
        channel_next    = channel_reg;
        pass_done_next  = pass_done_reg;
        strobe          = '0;
        case (phase_reg)
            PH_SET_MUX: begin
                strobe.mux_load = 1'b1;
                settle_cnt_next = '0;
                phase_next      = PH_SETTLE;
            end
            PH_SETTLE: begin
                if (settle_cnt_reg >= settle_ticks) begin
                    phase_next = PH_START;
                end else begin
                    settle_cnt_next = settle_cnt_reg + SETTLE_W'(1);
                end
            end
            PH_START: begin
                strobe.conv_start = 1'b1;
                phase_next        = PH_WAIT_EOC;
            end
            PH_WAIT_EOC: begin
                if (conv_done) begin
                    phase_next = PH_READ;
                end
            end
            PH_READ: begin
                strobe.sample_valid = 1'b1;
                phase_next          = PH_NEXT;
            end
            PH_NEXT: begin
                if (channel_inc >= limit) begin
                    channel_next   = '0;
                    pass_done_next = 1'b1;
                end else begin
                    channel_next = channel_inc[CH_W-1:0];
                end
                phase_next = PH_SET_MUX;
            end
            default: begin
                phase_next = PH_SET_MUX;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SET_MUX;
            settle_cnt_reg <= '0;
            channel_reg    <= '0;
            pass_done_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            settle_cnt_reg <= settle_cnt_next;
            channel_reg    <= channel_next;
            pass_done_reg  <= pass_done_next;
        end
    end

    assign channel   = channel_reg;
    assign scan_done = pass_done_next;

endmodule

/* rtl/core/mux_adc_scan_sequencer.sv */
`timescale 1ns / 1ps

// Scan sequencer for an ADC behind an analog multiplexer. Every word taken on the
// s_ channel is one timer tick and moves the sequencer one phase: set mux, settle
// (counts settle_ticks ticks), start conversion, wait for s_conv_done, read the
// sample into a per-channel store, and step to the next channel, wrapping after
// the configured number of channels and then holding m_scan_done high. Each tick
// returns one word on the m_ channel with the strobes, the stored sample and the
// store entry picked by s_read_index (as it stands after this tick's write). The
// step logic sits between the input ports and a single output register, and a new
// tick is taken every cycle while that register is empty or being drained. The
// sample store is cleared by reset. Configuration writes take effect at once and
// are meant to happen while no word is pending.
module mux_adc_scan_sequencer #(
    parameter int MAX_CHANNELS = adcseq_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = adcseq_pkg::SAMPLE_BITS_DEF,
    parameter int CH_W         = $clog2(MAX_CHANNELS)
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_we,
    input  logic [adcseq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adcseq_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_conv_done,
    input  logic [SAMPLE_BITS-1:0]             s_conv_sample,
    input  logic [CH_W-1:0]                    s_read_index,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [CH_W-1:0]                    m_mux_select,
    output logic                               m_mux_load,
    output logic                               m_conv_start,
    output logic                               m_sample_valid,
    output logic [CH_W-1:0]                    m_sample_channel,
    output logic [SAMPLE_BITS-1:0]             m_sample_value,
    output logic                               m_scan_done,
    output logic [SAMPLE_BITS-1:0]             m_read_value
);

    import adcseq_pkg::*;

    logic [SETTLE_W-1:0]    settle_ticks_reg;
    logic [COUNT_W-1:0]     scan_len_reg;
    logic                   s_fire;
    adcseq_strobe_t         strobe;
    logic [CH_W-1:0]        channel;
    logic                   scan_done;
    logic                   store_wr;
    logic [SAMPLE_BITS-1:0] read_value;

    logic                   m_valid_reg;
    logic [CH_W-1:0]        mux_select_reg;
    logic                   mux_load_reg;
    logic                   conv_start_reg;
    logic                   sample_valid_reg;
    logic [CH_W-1:0]        sample_channel_reg;
    logic [SAMPLE_BITS-1:0] sample_value_reg;
    logic                   scan_done_reg;
    logic [SAMPLE_BITS-1:0] read_value_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg <= SETTLE_RESET;
            scan_len_reg     <= COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SETTLE_TICKS: settle_ticks_reg <= cfg_wdata[SETTLE_W-1:0];
                CFG_SCAN_LEN:     scan_len_reg     <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A tick is taken whenever the output register is free or drains this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    adcseq_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CH_W         (CH_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (s_fire),
        .conv_done     (s_conv_done),
        .settle_ticks  (settle_ticks_reg),
        .scan_len      (scan_len_reg),
        .strobe        (strobe),
        .channel       (channel),
        .scan_done     (scan_done)
    );

    assign store_wr = s_fire && strobe.sample_valid;

    adcseq_store #(
        .DEPTH  (MAX_CHANNELS),
        .DATA_W (SAMPLE_BITS),
        .IDX_W  (CH_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (store_wr),
        .wr_addr (channel),
        .wr_data (s_conv_sample),
        .rd_addr (s_read_index),
        .rd_data (read_value)
    );

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mux_select_reg     <= channel;
            mux_load_reg       <= strobe.mux_load;
            conv_start_reg     <= strobe.conv_start;
            sample_valid_reg   <= strobe.sample_valid;
            sample_channel_reg <= strobe.sample_valid ? channel : '0;
            sample_value_reg   <= strobe.sample_valid ? s_conv_sample : '0;
            scan_done_reg      <= scan_done;
            read_value_reg     <= read_value;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_mux_select     = mux_select_reg;
    assign m_mux_load       = mux_load_reg;
    assign m_conv_start     = conv_start_reg;
    assign m_sample_valid   = sample_valid_reg;
    assign m_sample_channel = sample_channel_reg;
    assign m_sample_value   = sample_value_reg;
    assign m_scan_done      = scan_done_reg;
    assign m_read_value     = read_value_reg;

endmodule

/* rtl/core/adcseq_checker.sv */
`timescale 1ns / 1ps

module adcseq_checker #(
    parameter int SAMPLE_BITS = adcseq_pkg::SAMPLE_BITS_DEF,
    parameter int CH_W        = $clog2(adcseq_pkg::MAX_CHANNELS_DEF)
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_mux_load,
    input logic                   m_conv_start,
    input logic                   m_sample_valid,
    input logic [CH_W-1:0]        m_sample_channel,
    input logic [SAMPLE_BITS-1:0] m_sample_value,
    input logic                   m_scan_done
);

    logic done_seen_reg;

    // Remembers that a delivered word has already reported a finished pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_scan_done) begin
            done_seen_reg <= 1'b1;
        end
    end

    // A word is in at most one phase, so at most one strobe is set.
    a_one_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_mux_load, m_conv_start, m_sample_valid}))
        else $error("more than one strobe in a word");

    // Sample fields are zero on words that store nothing.
    a_sample_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_sample_valid) |-> (m_sample_channel == '0 && m_sample_value == '0))
        else $error("sample fields set without a stored sample");

    // Once reported, a finished pass stays reported.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && done_seen_reg) |-> m_scan_done)
        else $error("scan done flag dropped");

    // A pending word is not withdrawn.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word withdrawn before it was taken");

endmodule

bind mux_adc_scan_sequencer adcseq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CH_W        (CH_W)
) u_adcseq_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_mux_load       (m_mux_load),
    .m_conv_start     (m_conv_start),
    .m_sample_valid   (m_sample_valid),
    .m_sample_channel (m_sample_channel),
    .m_sample_value   (m_sample_value),
    .m_scan_done      (m_scan_done)
);
